FILE: src/nsfs_pkg.sv
// ----------------------------------------------------------------------------
// nsfs_pkg
// Shared types, codes and constants of the navigation source failover selector.
// ----------------------------------------------------------------------------
package nsfs_pkg;

  // Widths fixed by the item and register formats
  localparam int unsigned OpW       = 3;
  localparam int unsigned SensorW   = 2;
  localparam int unsigned SampleW   = 32;
  localparam int unsigned KindW     = 3;
  localparam int unsigned SrcW      = 2;
  localparam int unsigned TimeoutW  = 16;
  localparam int unsigned PrioW     = 8;
  localparam int unsigned HbW       = 16;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned NumSlots  = 4;

  // Default width of the freshness and report age counters
  localparam int unsigned AgeBitsDefault = 16;

  // Register reset values
  localparam logic [TimeoutW-1:0] TimeoutReset = 16'd50;
  localparam logic [PrioW-1:0]    PrioReset    = 8'd180;
  localparam logic [HbW-1:0]      HbReset      = 16'd50;

  // Q16.16 one, and the quality integer codes
  localparam logic [SampleW-1:0] QOne       = 32'h0001_0000;
  localparam logic [15:0]        QualFix    = 16'd1;
  localparam logic [15:0]        QualFloat  = 16'd2;
  localparam logic [15:0]        QualSingle = 16'd5;

  typedef enum logic [OpW-1:0] {
    OpTick    = 3'd0,
    OpX       = 3'd1,
    OpY       = 3'd2,
    OpSpeed   = 3'd3,
    OpHeading = 3'd4,
    OpLock    = 3'd5,
    OpQuality = 3'd6,
    OpSelect  = 3'd7
  } nsfs_op_e;

  typedef enum logic [SensorW-1:0] {
    SensGps     = 2'd0,
    SensRtk     = 2'd1,
    SensExp     = 2'd2,
    SensCompass = 2'd3
  } nsfs_sensor_e;

  typedef enum logic [SrcW-1:0] {
    SrcNone = 2'd0,
    SrcGps  = 2'd1,
    SrcRtk  = 2'd2,
    SrcExp  = 2'd3
  } nsfs_src_e;

  typedef enum logic [KindW-1:0] {
    KindX       = 3'd0,
    KindY       = 3'd1,
    KindSpeed   = 3'd2,
    KindHeading = 3'd3,
    KindReport  = 3'd4
  } nsfs_kind_e;

  typedef enum logic [1:0] {
    FixNone   = 2'd0,
    FixFix    = 2'd1,
    FixFloat  = 2'd2,
    FixSingle = 2'd3
  } nsfs_fix_e;

  typedef enum logic [1:0] {
    SlotRtkFix    = 2'd0,
    SlotRtkFloat  = 2'd1,
    SlotRtkSingle = 2'd2,
    SlotGps       = 2'd3
  } nsfs_slot_e;

  typedef enum logic [CfgIndexW-1:0] {
    RegTimeout   = 2'd0,
    RegPriority  = 2'd1,
    RegHeartbeat = 2'd2
  } nsfs_reg_e;

  typedef struct packed {
    logic [TimeoutW-1:0] timeout_ticks;
    logic [PrioW-1:0]    priority_list;
    logic [HbW-1:0]      heartbeat_ticks;
  } nsfs_cfg_t;

  typedef struct packed {
    nsfs_src_e src;
    logic      gps_locked;
    nsfs_fix_e rtk_fix;
    logic      exp_ready;
  } nsfs_flags_t;

  typedef struct packed {
    logic                      valid;
    nsfs_kind_e                kind;
    logic signed [SampleW-1:0] level;
    nsfs_src_e                 chosen;
  } nsfs_result_t;

endpackage

FILE: src/nsfs_cfg.sv
// ----------------------------------------------------------------------------
// nsfs_cfg
// Configuration register file: timeout, priority list and heartbeat period.
// ----------------------------------------------------------------------------
module nsfs_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [nsfs_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [nsfs_pkg::CfgDataW-1:0]   cfg_data_i,
  output nsfs_pkg::nsfs_cfg_t             cfg_o
);
  import nsfs_pkg::*;

  nsfs_cfg_t cfg_q;
  nsfs_cfg_t cfg_d;

  // Always ready: every write is taken and registered
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (nsfs_reg_e'(cfg_index_i))
        RegTimeout:   cfg_d.timeout_ticks   = cfg_data_i[TimeoutW-1:0];
        RegPriority:  cfg_d.priority_list   = cfg_data_i[PrioW-1:0];
        RegHeartbeat: cfg_d.heartbeat_ticks = cfg_data_i[HbW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks   <= TimeoutReset;
      cfg_q.priority_list   <= PrioReset;
      cfg_q.heartbeat_ticks <= HbReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: src/nsfs_step.sv
// ----------------------------------------------------------------------------
// nsfs_step
// Next-state and result logic for one item: ageing, priority walk, forwarding.
// ----------------------------------------------------------------------------
module nsfs_step #(
  parameter int unsigned AGE_BITS = nsfs_pkg::AgeBitsDefault
) (
  input  logic [nsfs_pkg::OpW-1:0]             op_i,
  input  logic [nsfs_pkg::SensorW-1:0]         sensor_i,
  input  logic signed [nsfs_pkg::SampleW-1:0]  sample_i,
  input  nsfs_pkg::nsfs_cfg_t                  cfg_i,
  input  nsfs_pkg::nsfs_flags_t                flags_i,
  input  logic [AGE_BITS-1:0]                  gps_age_i,
  input  logic [AGE_BITS-1:0]                  rtk_age_i,
  input  logic [AGE_BITS-1:0]                  exp_age_i,
  input  logic [AGE_BITS-1:0]                  report_age_i,
  output nsfs_pkg::nsfs_flags_t                flags_o,
  output logic [AGE_BITS-1:0]                  gps_age_o,
  output logic [AGE_BITS-1:0]                  rtk_age_o,
  output logic [AGE_BITS-1:0]                  exp_age_o,
  output logic [AGE_BITS-1:0]                  report_age_o,
  output nsfs_pkg::nsfs_result_t               result_o
);
  import nsfs_pkg::*;

  // Compare width covers both the counters and the 16-bit registers
  localparam int unsigned CmpW = (AGE_BITS > TimeoutW) ? AGE_BITS : TimeoutW;

  logic [AGE_BITS-1:0] gps_inc, rtk_inc, exp_inc, rep_inc;
  logic                gps_fresh, rtk_fresh, exp_fresh, hb_due;
  logic                rtk_avail, gps_avail;
  nsfs_src_e           best;
  nsfs_src_e           own;
  logic [15:0]         qual;
  nsfs_fix_e           fix_new;

  // Saturating increments
  assign gps_inc = (gps_age_i == '1)    ? gps_age_i    : gps_age_i + 1'b1;
  assign rtk_inc = (rtk_age_i == '1)    ? rtk_age_i    : rtk_age_i + 1'b1;
  assign exp_inc = (exp_age_i == '1)    ? exp_age_i    : exp_age_i + 1'b1;
  assign rep_inc = (report_age_i == '1) ? report_age_i : report_age_i + 1'b1;

  // Freshness after the tick's increment; a saturated age is always stale
  assign gps_fresh = (gps_inc != '1) &&
                     (CmpW'(gps_inc) < CmpW'(cfg_i.timeout_ticks));
  assign rtk_fresh = (rtk_inc != '1) &&
                     (CmpW'(rtk_inc) < CmpW'(cfg_i.timeout_ticks));
  assign exp_fresh = (exp_inc != '1) &&
                     (CmpW'(exp_inc) < CmpW'(cfg_i.timeout_ticks));
  assign hb_due    = (rep_inc == '1) ||
                     (CmpW'(rep_inc) > CmpW'(cfg_i.heartbeat_ticks));

  assign rtk_avail = rtk_fresh;
  assign gps_avail = gps_fresh && flags_i.gps_locked;

  // Walk the four priority slots, lowest slot first
  always_comb begin
    logic found;
    found = 1'b0;
    best  = SrcNone;
    for (int i = 0; i < NumSlots; i++) begin
      if (!found) begin
        unique case (nsfs_slot_e'(cfg_i.priority_list[2*i +: 2]))
          SlotGps: begin
            if (gps_avail) begin
              found = 1'b1;
              best  = SrcGps;
            end
          end
          SlotRtkFix: begin
            if (rtk_avail && flags_i.rtk_fix == FixFix) begin
              found = 1'b1;
              best  = SrcRtk;
            end
          end
          SlotRtkFloat: begin
            if (rtk_avail && flags_i.rtk_fix == FixFloat) begin
              found = 1'b1;
              best  = SrcRtk;
            end
          end
          default: begin
            if (rtk_avail && flags_i.rtk_fix == FixSingle) begin
              found = 1'b1;
              best  = SrcNone;
            end
          end
        endcase
      end
    end
  end

  // Source code of sensors gps, rtk and experiment
  assign own = nsfs_src_e'(sensor_i + 2'd1);

  // Quality integer part; negative values map to no fix
  assign qual = sample_i[SampleW-1] ? 16'd0 : sample_i[SampleW-1:16];

  always_comb begin
    if (qual == QualFix) begin
      fix_new = FixFix;
    end else if (qual == QualFloat) begin
      fix_new = FixFloat;
    end else if (qual == QualSingle) begin
      fix_new = FixSingle;
    end else begin
      fix_new = FixNone;
    end
  end

  // Per-item state update and result
  always_comb begin
    flags_o         = flags_i;
    gps_age_o       = gps_age_i;
    rtk_age_o       = rtk_age_i;
    exp_age_o       = exp_age_i;
    report_age_o    = report_age_i;
    result_o.valid  = 1'b0;
    result_o.kind   = KindReport;
    result_o.level  = '0;

    unique case (nsfs_op_e'(op_i))
      OpTick: begin
        gps_age_o         = gps_inc;
        rtk_age_o         = rtk_inc;
        exp_age_o         = exp_inc;
        report_age_o      = rep_inc;
        flags_o.exp_ready = exp_fresh;
        if ((flags_i.src != SrcExp || !exp_fresh) && best != flags_i.src) begin
          flags_o.src    = best;
          report_age_o   = '0;
          result_o.valid = 1'b1;
        end else if (hb_due) begin
          report_age_o   = '0;
          result_o.valid = 1'b1;
        end
      end
      OpX: begin
        unique case (nsfs_sensor_e'(sensor_i))
          SensGps: gps_age_o = '0;
          SensRtk: rtk_age_o = '0;
          SensExp: exp_age_o = '0;
          default: begin
          end
        endcase
        if (nsfs_sensor_e'(sensor_i) != SensCompass && flags_i.src == own) begin
          result_o.valid = 1'b1;
          result_o.kind  = KindX;
          result_o.level = sample_i;
        end
      end
      OpY: begin
        if (nsfs_sensor_e'(sensor_i) != SensCompass && flags_i.src == own) begin
          result_o.valid = 1'b1;
          result_o.kind  = KindY;
          result_o.level = sample_i;
        end
      end
      OpSpeed: begin
        if (nsfs_sensor_e'(sensor_i) != SensCompass && flags_i.src == own) begin
          result_o.valid = 1'b1;
          result_o.kind  = KindSpeed;
          result_o.level = sample_i;
        end
      end
      OpHeading: begin
        // Compass unless on experiment; experiment heading only on experiment
        if ((nsfs_sensor_e'(sensor_i) == SensCompass && flags_i.src != SrcExp) ||
            (nsfs_sensor_e'(sensor_i) == SensExp && flags_i.src == SrcExp)) begin
          result_o.valid = 1'b1;
          result_o.kind  = KindHeading;
          result_o.level = sample_i;
        end
      end
      OpLock: begin
        flags_o.gps_locked = (sample_i == QOne);
      end
      OpQuality: begin
        flags_o.rtk_fix = fix_new;
      end
      default: begin
        // Select: experiment on request when ready, otherwise none
        if (sample_i == QOne) begin
          if (flags_i.exp_ready && flags_i.src != SrcExp) begin
            flags_o.src    = SrcExp;
            report_age_o   = '0;
            result_o.valid = 1'b1;
          end
        end else if (flags_i.src != SrcNone) begin
          flags_o.src    = SrcNone;
          report_age_o   = '0;
          result_o.valid = 1'b1;
        end
      end
    endcase

    result_o.chosen = flags_o.src;
  end

endmodule

FILE: src/nav_source_failover_selector.sv
// ----------------------------------------------------------------------------
// nav_source_failover_selector
// Picks the navigation source and forwards its samples and source reports.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------
//  in      | input     | in_valid_i / in_stall_o  | op_i, sensor_i, sample_i
//  out     | output    | out_valid_o / out_stall_i| kind_o, level_o, chosen_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
//  One beat is taken every cycle unless in_stall_o is high. A beat waits in the
//  input register, where the step logic updates state and builds its result;
//  the result is then registered in the output register.
//  Reset leaves all sources stale, source none, and the first tick reports.
//  A held output beat stalls the input only when the waiting item has a result.
// ----------------------------------------------------------------------------
module nav_source_failover_selector #(
  parameter int unsigned AGE_BITS = nsfs_pkg::AgeBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [nsfs_pkg::OpW-1:0]            op_i,
  input  logic [nsfs_pkg::SensorW-1:0]        sensor_i,
  input  logic signed [nsfs_pkg::SampleW-1:0] sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [nsfs_pkg::KindW-1:0]          kind_o,
  output logic signed [nsfs_pkg::SampleW-1:0] level_o,
  output logic [nsfs_pkg::SrcW-1:0]           chosen_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [nsfs_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [nsfs_pkg::CfgDataW-1:0]       cfg_data_i
);
  import nsfs_pkg::*;

  nsfs_cfg_t                 cfg;

  logic                      in_valid_q;
  logic [OpW-1:0]            op_q;
  logic [SensorW-1:0]        sensor_q;
  logic signed [SampleW-1:0] sample_q;

  nsfs_flags_t               flags_q, flags_d;
  logic [AGE_BITS-1:0]       gps_age_q, gps_age_d;
  logic [AGE_BITS-1:0]       rtk_age_q, rtk_age_d;
  logic [AGE_BITS-1:0]       exp_age_q, exp_age_d;
  logic [AGE_BITS-1:0]       report_age_q, report_age_d;
  nsfs_result_t              result;

  logic                      out_valid_q;
  nsfs_kind_e                kind_q;
  logic signed [SampleW-1:0] level_q;
  nsfs_src_e                 chosen_q;

  logic                      out_free;
  logic                      advance;
  logic                      in_accept;

  nsfs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  nsfs_step #(
    .AGE_BITS (AGE_BITS)
  ) u_step (
    .op_i         (op_q),
    .sensor_i     (sensor_q),
    .sample_i     (sample_q),
    .cfg_i        (cfg),
    .flags_i      (flags_q),
    .gps_age_i    (gps_age_q),
    .rtk_age_i    (rtk_age_q),
    .exp_age_i    (exp_age_q),
    .report_age_i (report_age_q),
    .flags_o      (flags_d),
    .gps_age_o    (gps_age_d),
    .rtk_age_o    (rtk_age_d),
    .exp_age_o    (exp_age_d),
    .report_age_o (report_age_d),
    .result_o     (result)
  );

  // Advance the held item when it has no result or its result has somewhere to go
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!result.valid || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q     <= op_i;
      sensor_q <= sensor_i;
      sample_q <= sample_i;
    end
  end

  // Selector state: commit the step's update as the item retires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q.src        <= SrcNone;
      flags_q.gps_locked <= 1'b0;
      flags_q.rtk_fix    <= FixNone;
      flags_q.exp_ready  <= 1'b0;
      gps_age_q          <= '1;
      rtk_age_q          <= '1;
      exp_age_q          <= '1;
      report_age_q       <= '1;
    end else if (advance) begin
      flags_q      <= flags_d;
      gps_age_q    <= gps_age_d;
      rtk_age_q    <= rtk_age_d;
      exp_age_q    <= exp_age_d;
      report_age_q <= report_age_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && result.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result.valid) begin
      kind_q   <= result.kind;
      level_q  <= result.level;
      chosen_q <= result.chosen;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign level_o     = level_q;
  assign chosen_o    = chosen_q;

endmodule

FILE: src/nsfs_checker.sv
// ----------------------------------------------------------------------------
// nsfs_checker
// Port-level checks on the selector's output beats, bound to the top level.
// ----------------------------------------------------------------------------
module nsfs_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [nsfs_pkg::KindW-1:0]          kind_o,
  input logic signed [nsfs_pkg::SampleW-1:0] level_o,
  input logic [nsfs_pkg::SrcW-1:0]           chosen_o
);
  import nsfs_pkg::*;

  // A stalled output beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(level_o) && $stable(chosen_o))
    else $error("stalled output beat changed");

  // Source reports carry a zero level
  a_report_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindReport |-> level_o == '0)
    else $error("source report with non-zero level");

  // Kinds stay within nav x .. source report
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kind_o <= KindReport)
    else $error("output kind out of range");

  // Position and speed are forwarded only from a real source
  a_nav_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KindX || kind_o == KindY || kind_o == KindSpeed)
      |-> chosen_o != SrcNone)
    else $error("nav sample forwarded with no source chosen");

endmodule

bind nav_source_failover_selector nsfs_checker u_nsfs_checker (.*);
